[hw/rtl/ffra_pkg.sv]
// Package for the first-fit region allocator: operation, status and state codes,
// and the default sizes. It has no dependencies.
package ffra_pkg;

  localparam int unsigned DefaultMaxRegions = 64;
  localparam int unsigned DefaultAddrBits   = 32;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    BS_FREE     = 2'd0,
    BS_RESERVED = 2'd1,
    BS_UNMAPPED = 2'd2
  } bstate_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_DECIDE,
    S_LO_RD,
    S_LO_EV,
    S_HI_RD,
    S_HI_EV,
    S_FREE_FIN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_WR0,
    S_WR1,
    S_RESP
  } state_e;

endpackage

[hw/rtl/first_fit_region_allocator_top.sv]
// First-fit region allocator with coalescing: one sequencer around one region table memory.
// Depends on ffra_pkg.
//
//   Channel   Signals                                               Direction  Accept
//   command   start_i, operation_i, block_addr_i, block_count_i,    in         start_i && !busy_o
//             region_kind_i, busy_o
//   result    done_o, status_o, granted_addr_o, block_state_o      out        done_o (one cycle)
//
// Each item but a zero-size allocation walks the table, which is sorted by base, one entry
// at a time (memory read, then evaluate). Inserting or removing an entry shifts the entries
// above it through the same memory, one access a cycle (read, then write each entry), and
// then one or two final writes finish the item. The result appears in the cycle after the
// last write, and the block is busy until that result cycle is over.
// Reset empties the table by clearing the region count; the memory itself is not cleared.
// The receiver cannot stall: the result is held for exactly one cycle with done_o high.
module first_fit_region_allocator_top #(
  parameter int unsigned MAX_REGIONS = ffra_pkg::DefaultMaxRegions,
  parameter int unsigned ADDR_BITS   = ffra_pkg::DefaultAddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  operation_i,
  input  logic [31:0] block_addr_i,
  input  logic [31:0] block_count_i,
  input  logic        region_kind_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_addr_o,
  output logic [1:0]  block_state_o
);
  import ffra_pkg::*;

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IW = $clog2(MAX_REGIONS);

  // One table entry. The size keeps one extra bit, since merged regions can cover the
  // whole address space.
  typedef struct packed {
    logic [AW-1:0] base;
    logic [AW:0]   size;
    logic          free;
  } entry_t;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [AW-1:0] addr_q, addr_d, cnt_q, cnt_d;
  logic          kind_q, kind_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d;
  logic          found_q, found_d, have_prev_q, have_prev_d;
  entry_t        ent_q, ent_d, prev_q, prev_d, w0_q, w0_d, w1_q, w1_d;
  logic [CW-1:0] w0_idx_q, w0_idx_d;
  logic          w1_en_q, w1_en_d;
  logic [1:0]    k_q, k_d;
  logic [CW-1:0] mv_src_q, mv_src_d, mv_dst_q, mv_dst_d, mv_left_q, mv_left_d;
  logic          mv_up_q, mv_up_d;
  status_e       status_q, status_d;
  logic [AW-1:0] granted_q, granted_d;
  bstate_e       bstate_q, bstate_d;

  // Region table memory, one read and one write port, registered read data.
  entry_t        region_mem [MAX_REGIONS];
  entry_t        rd_data_q;
  logic          mem_re, mem_we;
  logic [IW-1:0] mem_raddr, mem_waddr;
  entry_t        mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      region_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= region_mem[mem_raddr];
    end
  end

  logic [AW-1:0] in_addr, in_cnt, clip_cnt;
  logic [CW-1:0] idx_p1, fin_src;
  entry_t        e;

  assign in_addr = AW'(block_addr_i);
  assign in_cnt  = AW'(block_count_i);
  // A loaded region that would run past the top of the address space ends at the top.
  assign clip_cnt = (in_cnt != '0 && (in_cnt - AW'(1)) > ~in_addr) ? (AW'(0) - in_addr)
                                                                      : in_cnt;
  assign idx_p1  = idx_q + CW'(1);
  assign fin_src = w0_idx_q + CW'(1) + CW'(k_q);
  assign e       = rd_data_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    count_d     = count_q;
    idx_d       = idx_q;
    found_d     = found_q;
    have_prev_d = have_prev_q;
    ent_d       = ent_q;
    prev_d      = prev_q;
    w0_d        = w0_q;
    w1_d        = w1_q;
    w0_idx_d    = w0_idx_q;
    w1_en_d     = w1_en_q;
    k_d         = k_q;
    mv_src_d    = mv_src_q;
    mv_dst_d    = mv_dst_q;
    mv_left_d   = mv_left_q;
    mv_up_d     = mv_up_q;
    status_d    = status_q;
    granted_d   = granted_q;
    bstate_d    = bstate_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d        = op_e'(operation_i);
          addr_d      = in_addr;
          cnt_d       = (op_e'(operation_i) == OP_LOAD) ? clip_cnt : in_cnt;
          kind_d      = region_kind_i;
          idx_d       = '0;
          found_d     = 1'b0;
          have_prev_d = 1'b0;
          status_d    = ST_OK;
          granted_d   = '0;
          bstate_d    = BS_FREE;
          if (op_e'(operation_i) == OP_ALLOC && in_cnt == '0) begin
            // A zero request fails without touching the table.
            status_d = ST_NO_FIT;
            state_d  = S_RESP;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          found_d = 1'b0;
          state_d = S_DECIDE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[IW-1:0];
          state_d   = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        logic stop;
        case (op_q)
          OP_ALLOC: stop = e.free && (e.size >= {1'b0, cnt_q});
          OP_QUERY: stop = e.base > addr_q;
          default:  stop = e.base >= addr_q;
        endcase
        if (stop) begin
          found_d = 1'b1;
          ent_d   = e;
          state_d = S_DECIDE;
        end else begin
          if (op_q == OP_QUERY) begin
            prev_d      = e;
            have_prev_d = 1'b1;
          end
          idx_d   = idx_p1;
          state_d = S_SCAN_RD;
        end
      end

      S_DECIDE: begin
        w1_en_d   = 1'b0;
        mv_left_d = '0;
        mv_up_d   = 1'b1;
        w0_idx_d  = idx_q;
        unique case (op_q)
          OP_QUERY: begin
            bstate_d = BS_UNMAPPED;
            if (have_prev_q && ({1'b0, addr_q - prev_q.base} < prev_q.size)) begin
              bstate_d = prev_q.free ? BS_FREE : BS_RESERVED;
            end
            state_d = S_RESP;
          end
          OP_LOAD: begin
            if (found_q && ent_q.base == addr_q) begin
              status_d = ST_DUPLICATE;
              state_d  = S_RESP;
            end else if (count_q == CW'(MAX_REGIONS)) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              mv_src_d  = count_q - CW'(1);
              mv_dst_d  = count_q;
              mv_left_d = count_q - idx_q;
              w0_d      = '{base: addr_q, size: {1'b0, cnt_q}, free: !kind_q};
              count_d   = count_q + CW'(1);
              state_d   = S_MOVE_RD;
            end
          end
          OP_ALLOC: begin
            if (!found_q) begin
              status_d = ST_NO_FIT;
              state_d  = S_RESP;
            end else if (ent_q.size == {1'b0, cnt_q}) begin
              w0_d      = '{base: ent_q.base, size: ent_q.size, free: 1'b0};
              granted_d = ent_q.base;
              state_d   = S_MOVE_RD;
            end else if (count_q == CW'(MAX_REGIONS)) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else begin
              // Split: reserved head at the found slot, free remainder right after it.
              mv_src_d  = count_q - CW'(1);
              mv_dst_d  = count_q;
              mv_left_d = count_q - idx_p1;
              w0_d      = '{base: ent_q.base, size: {1'b0, cnt_q}, free: 1'b0};
              w1_d      = '{base: ent_q.base + cnt_q, size: ent_q.size - {1'b0, cnt_q},
                            free: 1'b1};
              w1_en_d   = 1'b1;
              granted_d = ent_q.base;
              count_d   = count_q + CW'(1);
              state_d   = S_MOVE_RD;
            end
          end
          OP_FREE: begin
            if (!found_q || ent_q.base != addr_q) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_RESP;
            end else begin
              w0_d    = '{base: ent_q.base, size: ent_q.size, free: 1'b1};
              k_d     = '0;
              state_d = (idx_q != '0) ? S_LO_RD : S_HI_RD;
            end
          end
          default: state_d = S_RESP;
        endcase
      end

      S_LO_RD: begin
        mem_re    = 1'b1;
        mem_raddr = IW'(idx_q - CW'(1));
        state_d   = S_LO_EV;
      end

      S_LO_EV: begin
        if (e.free && ({1'b0, w0_q.base - e.base} == e.size)) begin
          w0_d     = '{base: e.base, size: e.size + w0_q.size, free: 1'b1};
          w0_idx_d = idx_q - CW'(1);
          k_d      = 2'd1;
        end
        state_d = S_HI_RD;
      end

      S_HI_RD: begin
        if (idx_p1 >= count_q) begin
          state_d = S_FREE_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_p1[IW-1:0];
          state_d   = S_HI_EV;
        end
      end

      S_HI_EV: begin
        if (e.free && ({1'b0, e.base - w0_q.base} == w0_q.size)) begin
          w0_d.size = w0_q.size + e.size;
          k_d       = k_q + 2'd1;
        end
        state_d = S_FREE_FIN;
      end

      S_FREE_FIN: begin
        // Close the gap left by the merged neighbors by moving the upper entries down.
        mv_up_d   = 1'b0;
        mv_src_d  = fin_src;
        mv_dst_d  = w0_idx_q + CW'(1);
        mv_left_d = (k_q == '0) ? '0 : (count_q - fin_src);
        count_d   = count_q - CW'(k_q);
        state_d   = S_MOVE_RD;
      end

      S_MOVE_RD: begin
        if (mv_left_q == '0) begin
          state_d = S_WR0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = mv_src_q[IW-1:0];
          state_d   = S_MOVE_WR;
        end
      end

      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mv_dst_q[IW-1:0];
        mem_wdata = e;
        mv_src_d  = mv_up_q ? (mv_src_q - CW'(1)) : (mv_src_q + CW'(1));
        mv_dst_d  = mv_up_q ? (mv_dst_q - CW'(1)) : (mv_dst_q + CW'(1));
        mv_left_d = mv_left_q - CW'(1);
        state_d   = S_MOVE_RD;
      end

      S_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = w0_idx_q[IW-1:0];
        mem_wdata = w0_q;
        state_d   = w1_en_q ? S_WR1 : S_RESP;
      end

      S_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(w0_idx_q + CW'(1));
        mem_wdata = w1_q;
        state_d   = S_RESP;
      end

      S_RESP: begin
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    cnt_q       <= cnt_d;
    kind_q      <= kind_d;
    idx_q       <= idx_d;
    found_q     <= found_d;
    have_prev_q <= have_prev_d;
    ent_q       <= ent_d;
    prev_q      <= prev_d;
    w0_q        <= w0_d;
    w1_q        <= w1_d;
    w0_idx_q    <= w0_idx_d;
    w1_en_q     <= w1_en_d;
    k_q         <= k_d;
    mv_src_q    <= mv_src_d;
    mv_dst_q    <= mv_dst_d;
    mv_left_q   <= mv_left_d;
    mv_up_q     <= mv_up_d;
    status_q    <= status_d;
    granted_q   <= granted_d;
    bstate_q    <= bstate_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = (state_q == S_RESP);
  assign status_o       = status_q;
  assign granted_addr_o = 32'(granted_q);
  assign block_state_o  = bstate_q;

endmodule

[hw/rtl/ffra_checker.sv]
// Port-level checks for the first-fit region allocator, bound to its top level.
// Depends on ffra_pkg and first_fit_region_allocator_top.
module ffra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [31:0] granted_addr_o,
  input logic [1:0]  block_state_o
);
  import ffra_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted item did not make the block busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result shown while idle");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o) else $error("result not a single cycle");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> granted_addr_o == '0)
    else $error("address granted on a failed item");

  a_state_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && block_state_o != BS_FREE |-> status_o == ST_OK)
    else $error("query answer with a failing status");

endmodule

bind first_fit_region_allocator_top ffra_checker u_ffra_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .status_o       (status_o),
  .granted_addr_o (granted_addr_o),
  .block_state_o  (block_state_o)
);
